// ----- rtl/core/afwi_pkg.sv -----
// shared constants and types for the api frame receiver with modem init
// no dependencies
package afwi_pkg;

    localparam logic [7:0] HEADER_BYTES      = 8'd5;
    localparam logic [7:0] CARRIAGE_RETURN   = 8'd13;
    localparam logic [7:0] DELIM_RESET       = 8'd126;

    typedef enum logic [2:0] {
        EV_HEADER    = 3'd0,
        EV_PAYLOAD   = 3'd1,
        EV_CHECKSUM  = 3'd2,
        EV_ENTER_CMD = 3'd3,
        EV_SEND_AP1  = 3'd4,
        EV_SEND_CN   = 3'd5,
        EV_READY     = 3'd6
    } event_t;

    typedef struct packed {
        event_t      event_res;
        logic [7:0]  out_byte;
        logic [7:0]  byte_index;
        logic [7:0]  payload_length;
        logic        length_error;
    } result_t;

endpackage

// ----- rtl/core/afwi_ifs.sv -----
// valid/ready channel interfaces for the api frame receiver
// no dependencies
interface afwi_rx_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] rx_byte;

    modport source (output valid, func, rx_byte, input ready);
    modport sink   (input valid, func, rx_byte, output ready);
endinterface

interface afwi_ev_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_res;
    logic [7:0] out_byte;
    logic [7:0] byte_index;
    logic [7:0] payload_length;
    logic       length_error;

    modport source (output valid, event_res, out_byte, byte_index, payload_length,
                    length_error, input ready);
    modport sink   (input valid, event_res, out_byte, byte_index, payload_length,
                    length_error, output ready);
endinterface

// ----- rtl/core/api_frame_receiver_with_init.sv -----
// top level of the api frame receiver with modem init sequencer
// depends on afwi_pkg, afwi_ifs, afwi_step and afwi_res_reg
//
// usage:
//   rx  : one transaction per item; func=1 starts or restarts modem init,
//         func=0 delivers one received serial byte in rx_byte
//   evt : zero or one result per item (header, payload, checksum byte or
//         an init request: enter command mode, ATAP1, ATCN, link ready)
//   cfg_wr_en / cfg_wr_data : write the frame start delimiter (reset 0x7e)
// a result is registered and presented in the cycle after its item is accepted
// throughput: one item per cycle unless evt stalls; the state update and
//   result selection sit between the accepted item and the result register
// bytes that produce no result (delimiter, length bytes, idle line, non-CR
//   bytes during init) are still accepted and leave the result slot empty
// reset: link status unknown, parser waiting for the delimiter, no result
//   pending; the delimiter register returns to 0x7e
// stall: rx.ready stays high while the result register is empty or is
//   being taken; if evt is stalled with a result held, rx.ready drops
module api_frame_receiver_with_init (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    afwi_rx_if.sink     rx,
    afwi_ev_if.source   evt
);

    logic              ready;
    logic              fire;
    logic              res_hit;
    afwi_pkg::result_t res;

    assign rx.ready = ready;
    assign fire     = rx.valid && ready;

    afwi_step u_step (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fire        (fire),
        .func        (rx.func),
        .rx_byte     (rx.rx_byte),
        .res_hit     (res_hit),
        .res         (res)
    );

    afwi_res_reg u_res_reg (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .res_hit (res_hit),
        .res     (res),
        .ready   (ready),
        .evt     (evt)
    );

endmodule

// ----- rtl/core/afwi_step.sv -----
// link sequencer and frame parser: state registers and per-byte next-state logic
// depends on afwi_pkg
module afwi_step (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [7:0]          cfg_wr_data,
    input  logic                fire,
    input  logic                func,
    input  logic [7:0]          rx_byte,
    output logic                res_hit,
    output afwi_pkg::result_t   res
);

    typedef enum logic [2:0] {
        LINK_UNKNOWN = 3'd0,
        LINK_INIT1   = 3'd1,
        LINK_INIT2   = 3'd2,
        LINK_INIT3   = 3'd3,
        LINK_READY   = 3'd4
    } link_t;

    typedef enum logic [2:0] {
        PS_WAIT   = 3'd0,
        PS_LEN_HI = 3'd1,
        PS_LEN_LO = 3'd2,
        PS_HEADER = 3'd3,
        PS_DATA   = 3'd4,
        PS_CHECK  = 3'd5
    } parse_t;

    logic [7:0] delim_reg;
    link_t      link_reg,  link_next;
    parse_t     parse_reg, parse_next;
    logic [7:0] cnt_reg,   cnt_next;
    logic [7:0] plen_reg,  plen_next;
    logic       lbad_reg,  lbad_next;
    logic [7:0] cnt_inc;

    assign cnt_inc = cnt_reg + 8'd1;

    always_comb
    begin
        link_next          = link_reg;
        parse_next         = parse_reg;
        cnt_next           = cnt_reg;
        plen_next          = plen_reg;
        lbad_next          = lbad_reg;
        res_hit            = 1'b0;
        res.event_res      = afwi_pkg::EV_HEADER;
        res.out_byte       = '0;
        res.byte_index     = '0;
        res.payload_length = '0;
        res.length_error   = 1'b0;

        if (func)
        begin
            link_next     = LINK_INIT1;
            res_hit       = 1'b1;
            res.event_res = afwi_pkg::EV_ENTER_CMD;
        end
        else
        begin
            unique case (link_reg)
                LINK_INIT1:
                begin
                    if (rx_byte == afwi_pkg::CARRIAGE_RETURN)
                    begin
                        link_next     = LINK_INIT2;
                        res_hit       = 1'b1;
                        res.event_res = afwi_pkg::EV_SEND_AP1;
                    end
                end
                LINK_INIT2:
                begin
                    if (rx_byte == afwi_pkg::CARRIAGE_RETURN)
                    begin
                        link_next     = LINK_INIT3;
                        res_hit       = 1'b1;
                        res.event_res = afwi_pkg::EV_SEND_CN;
                    end
                end
                LINK_INIT3:
                begin
                    if (rx_byte == afwi_pkg::CARRIAGE_RETURN)
                    begin
                        link_next     = LINK_READY;
                        res_hit       = 1'b1;
                        res.event_res = afwi_pkg::EV_READY;
                    end
                end
                LINK_READY:
                begin
                    // frame fields carry the stored length of the current frame
                    res.out_byte       = rx_byte;
                    res.payload_length = plen_reg;
                    res.length_error   = lbad_reg;
                    unique case (parse_reg)
                        PS_LEN_HI:
                        begin
                            parse_next = PS_LEN_LO;
                        end
                        PS_LEN_LO:
                        begin
                            if (rx_byte < afwi_pkg::HEADER_BYTES)
                            begin
                                lbad_next = 1'b1;
                                plen_next = '0;
                            end
                            else
                            begin
                                lbad_next = 1'b0;
                                plen_next = rx_byte - afwi_pkg::HEADER_BYTES;
                            end
                            cnt_next   = '0;
                            parse_next = PS_HEADER;
                        end
                        PS_HEADER:
                        begin
                            res_hit        = 1'b1;
                            res.event_res  = afwi_pkg::EV_HEADER;
                            res.byte_index = cnt_reg;
                            cnt_next       = cnt_inc;
                            if (cnt_inc >= afwi_pkg::HEADER_BYTES)
                            begin
                                cnt_next   = '0;
                                parse_next = (plen_reg != 8'd0) ? PS_DATA : PS_CHECK;
                            end
                        end
                        PS_DATA:
                        begin
                            res_hit        = 1'b1;
                            res.event_res  = afwi_pkg::EV_PAYLOAD;
                            res.byte_index = cnt_reg;
                            cnt_next       = cnt_inc;
                            if (cnt_inc >= plen_reg)
                            begin
                                cnt_next   = '0;
                                parse_next = PS_CHECK;
                            end
                        end
                        PS_CHECK:
                        begin
                            res_hit       = 1'b1;
                            res.event_res = afwi_pkg::EV_CHECKSUM;
                            parse_next    = PS_WAIT;
                        end
                        default:
                        begin
                            parse_next = (rx_byte == delim_reg) ? PS_LEN_HI : PS_WAIT;
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg <= afwi_pkg::DELIM_RESET;
            link_reg  <= LINK_UNKNOWN;
            parse_reg <= PS_WAIT;
            cnt_reg   <= '0;
            plen_reg  <= '0;
            lbad_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                delim_reg <= cfg_wr_data;
            end
            if (fire)
            begin
                link_reg  <= link_next;
                parse_reg <= parse_next;
                cnt_reg   <= cnt_next;
                plen_reg  <= plen_next;
                lbad_reg  <= lbad_next;
            end
        end
    end

    // a start command always lands in the first init stage
    a_start_init1: assert property (@(posedge clk) disable iff (!rst_n)
        fire && func |=> link_reg == LINK_INIT1)
        else $error("start command did not enter init1");

    // parser only moves on an accepted transaction
    a_parse_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(parse_reg) && $stable(cnt_reg) && $stable(link_reg))
        else $error("parser state changed without a transaction");

    a_header_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        parse_reg == PS_HEADER |-> cnt_reg < afwi_pkg::HEADER_BYTES)
        else $error("header count out of range");

    // payload phase is never entered for an empty payload
    a_data_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        parse_reg == PS_DATA |-> cnt_reg < plen_reg)
        else $error("payload count beyond frame length");

endmodule

// ----- rtl/core/afwi_res_reg.sv -----
// result register: holds one result while the sink stalls, refills in the same cycle
// depends on afwi_pkg and afwi_ifs
module afwi_res_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  logic               res_hit,
    input  afwi_pkg::result_t  res,
    output logic               ready,
    afwi_ev_if.source          evt
);

    logic              valid_reg;
    afwi_pkg::result_t data_reg;

    assign ready = !valid_reg || evt.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            valid_reg <= res_hit;
        end
        else if (evt.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && res_hit)
        begin
            data_reg <= res;
        end
    end

    assign evt.valid          = valid_reg;
    assign evt.event_res      = data_reg.event_res;
    assign evt.out_byte       = data_reg.out_byte;
    assign evt.byte_index     = data_reg.byte_index;
    assign evt.payload_length = data_reg.payload_length;
    assign evt.length_error   = data_reg.length_error;

endmodule
